@@ hdl/maf_pkg.sv @@
// Shared constants for the moving-average filter.
// No dependencies; used by the channel interfaces and the filter top level.
`timescale 1ns / 1ps

package maf_pkg;

  localparam int MAX_WINDOW  = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_BITS   = $clog2(MAX_WINDOW);
  localparam int WIN_BITS    = 9;
  localparam int COUNT_BITS  = 9;
  localparam int SUM_BITS    = SAMPLE_BITS + ADDR_BITS + 1;

  localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(8);

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

endpackage

@@ hdl/maf_if.sv @@
// Valid/ready channel interfaces for the moving-average filter:
// sample requests, result requests and window configuration writes.
// Depends on maf_pkg.
`timescale 1ns / 1ps

interface maf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   mode;
  logic signed [maf_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface maf_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [maf_pkg::SAMPLE_BITS-1:0] mean;
  logic        [maf_pkg::COUNT_BITS-1:0]  samples_used;

  modport source (output valid, output mean, output samples_used, input ready);
  modport sink   (input valid, input mean, input samples_used, output ready);
endinterface

interface maf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [maf_pkg::WIN_BITS-1:0]    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/moving_average_filter.sv @@
// Boxcar moving-average filter: history ring memory, running sum, radix-4 divider.
// Depends on maf_pkg and the channel interfaces in maf_if.sv.
//
//   channel   dir   payload                     note
//   in_ch     in    mode, sample                clear or add request
//   out_ch    out   mean, samples_used          one per add request
//   cfg_ch    in    data (window_size)          always ready
//
// An add request goes from acceptance to the next ready through one history read, one
// sum update, one magnitude load, 13 two-bit divider steps and one result load, which
// waits while the output register is stalled. A clear request gives no result.
// Reset clears the pointer, sum, fill count and sets the window to 8; the history
// memory is not cleared. A stalled result holds in the output register while the
// next request is taken; a finished quotient waits until that register frees.
`timescale 1ns / 1ps

module moving_average_filter (
  input  logic      clk,
  input  logic      rst_n,
  maf_in_if.sink    in_ch,
  maf_out_if.source out_ch,
  maf_cfg_if.sink   cfg_ch
);

  import maf_pkg::*;

  localparam int DIV_BITS  = SUM_BITS + (SUM_BITS % 2);
  localparam int DIV_STEPS = DIV_BITS / 2;
  localparam int CNT_BITS  = $clog2(DIV_STEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_ABS  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [SUM_BITS-1:0] POS_LIMIT = SUM_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [SUM_BITS-1:0] NEG_LIMIT = SUM_BITS'(1 << (SAMPLE_BITS - 1));

  logic [2:0]                    state_r, state_nxt;
  logic [WIN_BITS-1:0]           window_r;
  logic [WIN_BITS-1:0]           w_eff;
  logic [ADDR_BITS-1:0]          wp_r, wp_nxt;
  logic signed [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [COUNT_BITS-1:0]         fill_r, fill_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [CNT_BITS-1:0]           cnt_r, cnt_nxt;
  logic [DIV_BITS-1:0]           quo_r, quo_nxt;
  logic [COUNT_BITS-1:0]         rem_r, rem_nxt;
  logic                          neg_r, neg_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] mean_r, mean_nxt;
  logic [COUNT_BITS-1:0]         used_r, used_nxt;

  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic [ADDR_BITS-1:0]          rd_addr;
  logic                          in_acc;
  logic                          rd_en;
  logic                          wr_en;
  logic                          load_out;
  logic [SUM_BITS-1:0]           mag;
  logic [SUM_BITS-1:0]           quot;
  logic signed [SAMPLE_BITS-1:0] mean_val;
  logic [COUNT_BITS:0]           rem_sh;
  logic [COUNT_BITS-1:0]         rem_w;
  logic [DIV_BITS-1:0]           quo_w;
  logic                          do_sub;
  logic signed [SUM_BITS-1:0]    x_ext;
  logic signed [SUM_BITS-1:0]    old_ext;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.mean         = mean_r;
  assign out_ch.samples_used = used_r;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign rd_en   = in_acc && (in_ch.mode == MODE_ADD);
  assign wr_en   = (state_r == S_SUM);
  assign rd_addr = wp_r - w_eff[ADDR_BITS-1:0];

  always_comb begin
    if (window_r == '0) begin
      w_eff = WIN_BITS'(1);
    end else if (window_r > WIN_BITS'(MAX_WINDOW)) begin
      w_eff = WIN_BITS'(MAX_WINDOW);
    end else begin
      w_eff = window_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wp_r] <= sample_r;
    end
    if (rd_en) begin
      rd_data_r <= hist_mem[rd_addr];
    end
  end

  assign x_ext   = SUM_BITS'(sample_r);
  assign old_ext = SUM_BITS'(rd_data_r);
  assign do_sub  = (fill_r >= w_eff);
  assign mag     = sum_r[SUM_BITS-1] ? (~sum_r + SUM_BITS'(1)) : sum_r;
  assign quot    = quo_r[SUM_BITS-1:0];

  always_comb begin
    if (!neg_r && (quot > POS_LIMIT)) begin
      mean_val = SAMPLE_BITS'(POS_LIMIT);
    end else if (neg_r && (quot > NEG_LIMIT)) begin
      mean_val = SAMPLE_BITS'(NEG_LIMIT);
    end else if (neg_r) begin
      mean_val = -SAMPLE_BITS'(quot);
    end else begin
      mean_val = SAMPLE_BITS'(quot);
    end
  end

  always_comb begin
    rem_w = rem_r;
    quo_w = quo_r;
    for (int i = 0; i < 2; i++) begin
      rem_sh = {rem_w, quo_w[DIV_BITS-1]};
      quo_w  = {quo_w[DIV_BITS-2:0], 1'b0};
      if (rem_sh >= {1'b0, fill_r}) begin
        rem_sh   = rem_sh - {1'b0, fill_r};
        quo_w[0] = 1'b1;
      end
      rem_w = rem_sh[COUNT_BITS-1:0];
    end
  end

  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    sum_nxt       = sum_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    mean_nxt      = mean_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.mode == MODE_CLEAR) begin
            wp_nxt   = '0;
            sum_nxt  = '0;
            fill_nxt = '0;
          end else begin
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (do_sub) begin
          sum_nxt = sum_r + x_ext - old_ext;
        end else begin
          sum_nxt  = sum_r + x_ext;
          fill_nxt = fill_r + COUNT_BITS'(1);
        end
        wp_nxt    = wp_r + ADDR_BITS'(1);
        state_nxt = S_ABS;
      end
      S_ABS: begin
        neg_nxt   = sum_r[SUM_BITS-1];
        quo_nxt   = DIV_BITS'(mag);
        rem_nxt   = '0;
        cnt_nxt   = CNT_BITS'(DIV_STEPS - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        quo_nxt = quo_w;
        rem_nxt = rem_w;
        if (cnt_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r - CNT_BITS'(1);
        end
      end
      S_OUT: begin
        if (load_out) begin
          mean_nxt      = mean_val;
          used_nxt      = fill_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      window_r    <= WIN_RESET;
      wp_r        <= '0;
      sum_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      sum_r       <= sum_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        window_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_ch.sample;
    end
    cnt_r  <= cnt_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    mean_r <= mean_nxt;
    used_r <= used_nxt;
  end

endmodule
